FILE: sv/assert_macros.svh
// Assertion helpers for the decoder. All checks are sampled on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted
`define IRPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds during reset
`define IRPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/irpd_pkg.sv
package irpd_pkg;

    // Frame length in bytes plus one (last byte index ends the frame)
    localparam int BUF_SIZE = 5;

    localparam int TIME_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int BITC_W  = 3;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam logic [IDX_W-1:0]  LAST_BYTE = IDX_W'(BUF_SIZE - 1);
    localparam logic [BITC_W-1:0] LAST_BIT  = 3'd7;

    // Threshold reset values, timer ticks
    localparam logic [TIME_W-1:0] START_MAX_RST = 16'd3600;
    localparam logic [TIME_W-1:0] START_TH_RST  = 16'd3100;
    localparam logic [TIME_W-1:0] BIT_MAX_RST   = 16'd650;
    localparam logic [TIME_W-1:0] BIT_TH_RST    = 16'd420;

    // Register index, byte address = 4 * index
    typedef enum logic [1:0] {
        REG_START_MAX = 2'd0,
        REG_START_TH  = 2'd1,
        REG_BIT_MAX   = 2'd2,
        REG_BIT_TH    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'b01,
        MODE_RECV = 2'b10
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0] start_max;
        logic [TIME_W-1:0] start_th;
        logic [TIME_W-1:0] bit_max;
        logic [TIME_W-1:0] bit_th;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] last_capture;
        t_mode             mode;
        logic [BYTE_W-1:0] shift_byte;
        logic [BITC_W-1:0] bit_count;
        logic [IDX_W-1:0]  byte_count;
        logic [BYTE_W-1:0] repeats;
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic              receiving;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_done;
        logic [BYTE_W-1:0] repeat_count;
    } t_result;

endpackage

FILE: sv/irpd_in_if.sv
interface irpd_in_if;
    logic                       valid;
    logic                       ready;
    logic [irpd_pkg::TIME_W-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

FILE: sv/irpd_out_if.sv
interface irpd_out_if;
    logic                        valid;
    logic                        ready;
    logic [irpd_pkg::TIME_W-1:0] interval;
    logic                        receiving;
    logic                        byte_valid;
    logic [irpd_pkg::BYTE_W-1:0] byte_value;
    logic [irpd_pkg::IDX_W-1:0]  byte_index;
    logic                        frame_done;
    logic [irpd_pkg::BYTE_W-1:0] repeat_count;

    modport source (output valid, output interval, output receiving, output byte_valid,
                    output byte_value, output byte_index, output frame_done,
                    output repeat_count, input ready);
    modport sink   (input valid, input interval, input receiving, input byte_valid,
                    input byte_value, input byte_index, input frame_done,
                    input repeat_count, output ready);
endinterface

FILE: sv/ir_pulse_distance_decoder.sv
// Pulse-distance IR frame decoder.
// i_cap (valid/ready sink) takes one 16-bit timer capture per input edge.
// o_res (valid/ready source) returns exactly one result per capture: the
// interval to the previous capture, the receive flag, a completed byte with
// its index and a frame-done flag, and the repeat count.
// Thresholds sit in four 16-bit registers on the APB port at byte
// addresses 0, 4, 8 and 12 (start_max, start_th, bit_max, bit_th).
// A capture accepted at one edge shows its result on o_res from the next
// cycle on. One capture per cycle while the receiver keeps o_res ready, set by
// the single result register behind the decode logic.
// A capture is taken whenever the result register is empty or being read
// in the same cycle; when the receiver stalls with a result pending, i_cap
// ready drops and the result holds.
// Reset (synchronous, active low) sets the thresholds to their defaults,
// clears the decoder state to idle and empties the result register.
`include "assert_macros.svh"

module ir_pulse_distance_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    irpd_in_if.sink                      i_cap,
    irpd_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [irpd_pkg::DATA_W-1:0]  pwdata,
    output logic [irpd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    irpd_pkg::t_cfg    w_cfg;
    irpd_pkg::t_state  r_state;
    irpd_pkg::t_state  n_state;
    irpd_pkg::t_result r_res;
    irpd_pkg::t_result n_res;
    logic              r_out_valid;
    logic              w_acc_in;

    irpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    irpd_step u_step (
        .i_capture_time (i_cap.capture_time),
        .i_cfg          (w_cfg),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (n_res)
    );

    // handshake: take a request when the result slot is free or draining
    assign i_cap.ready = !r_out_valid || o_res.ready;
    assign w_acc_in    = i_cap.valid && i_cap.ready;

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_capture <= '0;
            r_state.mode         <= irpd_pkg::MODE_IDLE;
            r_state.shift_byte   <= '0;
            r_state.bit_count    <= '0;
            r_state.byte_count   <= '0;
            r_state.repeats      <= '0;
        end else if (w_acc_in) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc_in) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.interval     = r_res.interval;
    assign o_res.receiving    = r_res.receiving;
    assign o_res.byte_valid   = r_res.byte_valid;
    assign o_res.byte_value   = r_res.byte_value;
    assign o_res.byte_index   = r_res.byte_index;
    assign o_res.frame_done   = r_res.frame_done;
    assign o_res.repeat_count = r_res.repeat_count;

    // an empty result slot never blocks the input
    `IRPD_ASSERT(a_ready_when_empty, !r_out_valid |-> i_cap.ready, "input blocked while empty")
    // a request taken in idle cannot complete a byte
    `IRPD_ASSERT(a_no_byte_in_idle, (w_acc_in && r_state.mode == irpd_pkg::MODE_IDLE) |=> !r_res.byte_valid, "byte completed in idle")
    // a completed byte leaves the bit counter at zero
    `IRPD_ASSERT(a_bitcnt_clear, (w_acc_in && n_res.byte_valid) |=> r_state.bit_count == '0, "bit count not cleared")
    // frame end returns to idle with a byte reported
    `IRPD_ASSERT(a_frame_end, (r_out_valid && r_res.frame_done) |-> (r_res.byte_valid && !r_res.receiving), "bad frame end")
    // after reset the result slot is empty
    `IRPD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

FILE: sv/irpd_regs.sv
module irpd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [irpd_pkg::DATA_W-1:0]   pwdata,
    output logic [irpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output irpd_pkg::t_cfg                o_cfg
);

    irpd_pkg::t_cfg   r_cfg;
    irpd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    // word index, low address bits ignored
    assign w_idx  = irpd_pkg::t_reg_idx'(paddr[irpd_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // threshold registers, low 16 bits of the write data kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_max <= irpd_pkg::START_MAX_RST;
            r_cfg.start_th  <= irpd_pkg::START_TH_RST;
            r_cfg.bit_max   <= irpd_pkg::BIT_MAX_RST;
            r_cfg.bit_th    <= irpd_pkg::BIT_TH_RST;
        end else if (w_wr) begin
            case (w_idx)
                irpd_pkg::REG_START_MAX: r_cfg.start_max <= pwdata[irpd_pkg::TIME_W-1:0];
                irpd_pkg::REG_START_TH:  r_cfg.start_th  <= pwdata[irpd_pkg::TIME_W-1:0];
                irpd_pkg::REG_BIT_MAX:   r_cfg.bit_max   <= pwdata[irpd_pkg::TIME_W-1:0];
                irpd_pkg::REG_BIT_TH:    r_cfg.bit_th    <= pwdata[irpd_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            irpd_pkg::REG_START_MAX: prdata = irpd_pkg::DATA_W'(r_cfg.start_max);
            irpd_pkg::REG_START_TH:  prdata = irpd_pkg::DATA_W'(r_cfg.start_th);
            irpd_pkg::REG_BIT_MAX:   prdata = irpd_pkg::DATA_W'(r_cfg.bit_max);
            irpd_pkg::REG_BIT_TH:    prdata = irpd_pkg::DATA_W'(r_cfg.bit_th);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/irpd_step.sv
module irpd_step (
    input  logic [irpd_pkg::TIME_W-1:0] i_capture_time,
    input  irpd_pkg::t_cfg              i_cfg,
    input  irpd_pkg::t_state            i_state,
    output irpd_pkg::t_state            o_state,
    output irpd_pkg::t_result           o_result
);

    logic [irpd_pkg::TIME_W-1:0] w_span;
    logic [irpd_pkg::BYTE_W-1:0] w_acc;
    logic [irpd_pkg::IDX_W-1:0]  w_next_cnt;

    // interval: plain difference if newer is larger, else one tick short (equal -> all ones)
    always_comb begin
        if (i_capture_time > i_state.last_capture) begin
            w_span = i_capture_time - i_state.last_capture;
        end else begin
            w_span = i_capture_time - i_state.last_capture - 16'd1;
        end
    end

    // new bit enters at the top, shifts down toward bit 0
    assign w_acc      = i_state.shift_byte | {w_span > i_cfg.bit_th, 7'd0};
    assign w_next_cnt = i_state.byte_count + 6'd1;

    // mode and frame update
    always_comb begin
        o_state                 = i_state;
        o_state.last_capture    = i_capture_time;
        o_result                = '0;
        o_result.interval       = w_span;
        case (i_state.mode)
            irpd_pkg::MODE_IDLE: begin
                if (w_span < i_cfg.start_max) begin
                    if (w_span > i_cfg.start_th) begin
                        o_state.shift_byte = '0;
                        o_state.bit_count  = '0;
                        o_state.byte_count = '0;
                        o_state.repeats    = '0;
                        o_state.mode       = irpd_pkg::MODE_RECV;
                    end else begin
                        o_state.repeats = i_state.repeats + 8'd1;
                    end
                end
            end
            irpd_pkg::MODE_RECV: begin
                if (w_span < i_cfg.bit_max) begin
                    if (i_state.bit_count == irpd_pkg::LAST_BIT) begin
                        o_result.byte_valid = 1'b1;
                        o_result.byte_value = w_acc;
                        o_result.byte_index = i_state.byte_count;
                        o_state.shift_byte  = '0;
                        o_state.bit_count   = '0;
                        o_state.byte_count  = w_next_cnt;
                        if (w_next_cnt == irpd_pkg::LAST_BYTE) begin
                            o_result.frame_done = 1'b1;
                            o_state.mode        = irpd_pkg::MODE_IDLE;
                        end
                    end else begin
                        o_state.shift_byte = w_acc >> 1;
                        o_state.bit_count  = i_state.bit_count + 3'd1;
                    end
                end
            end
            default: o_state.mode = irpd_pkg::MODE_IDLE;
        endcase
        o_result.receiving    = (o_state.mode == irpd_pkg::MODE_RECV);
        o_result.repeat_count = o_state.repeats;
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int FRAME_BITS  = (irpd_pkg::BUF_SIZE - 1) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_STALL  = 80;

    // Decoder tracker: mirrors the thresholds and the decode state, and
    // holds the results still owed by the block, oldest first.
    class ir_frame_tracker;
        irpd_pkg::t_cfg              cfg;
        logic [irpd_pkg::TIME_W-1:0] last_capture;
        irpd_pkg::t_mode             mode;
        logic [irpd_pkg::BYTE_W-1:0] shift_byte;
        logic [irpd_pkg::BITC_W-1:0] bit_count;
        logic [irpd_pkg::IDX_W-1:0]  byte_count;
        logic [irpd_pkg::BYTE_W-1:0] repeats;
        irpd_pkg::t_result           expected_results[$];
        int                          errors;
        int                          n_checked;
        int                          n_bytes;
        int                          n_frames;
        int                          n_wraps;

        function new();
            cfg          = '{irpd_pkg::START_MAX_RST, irpd_pkg::START_TH_RST,
                             irpd_pkg::BIT_MAX_RST, irpd_pkg::BIT_TH_RST};
            last_capture = '0;
            mode         = irpd_pkg::MODE_IDLE;
            shift_byte   = '0;
            bit_count    = '0;
            byte_count   = '0;
            repeats      = '0;
        endfunction

        function void set_reg(irpd_pkg::t_reg_idx idx, logic [irpd_pkg::TIME_W-1:0] v);
            case (idx)
                irpd_pkg::REG_START_MAX: cfg.start_max = v;
                irpd_pkg::REG_START_TH:  cfg.start_th  = v;
                irpd_pkg::REG_BIT_MAX:   cfg.bit_max   = v;
                irpd_pkg::REG_BIT_TH:    cfg.bit_th    = v;
                default: ;
            endcase
        endfunction

        function bit in_frame();
            return mode == irpd_pkg::MODE_RECV;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Decode one accepted capture and queue the result it must produce
        function void note_capture(logic [irpd_pkg::TIME_W-1:0] now);
            irpd_pkg::t_result           r;
            logic [irpd_pkg::TIME_W-1:0] span;
            logic [irpd_pkg::BYTE_W-1:0] acc;
            r = '0;
            // equal captures give 65535, a backward step wraps one short
            if (now > last_capture) span = now - last_capture;
            else span = now + 16'hFFFF - last_capture;
            last_capture = now;

            if (mode == irpd_pkg::MODE_IDLE) begin
                if (span < cfg.start_max) begin
                    if (span > cfg.start_th) begin
                        shift_byte = '0;
                        bit_count  = '0;
                        byte_count = '0;
                        repeats    = '0;
                        mode       = irpd_pkg::MODE_RECV;
                    end else begin
                        if (repeats == 8'hFF) n_wraps++;
                        repeats = repeats + 1'b1;
                    end
                end
            end else if (span < cfg.bit_max) begin
                acc = shift_byte;
                if (span > cfg.bit_th) acc[7] = 1'b1;
                if (bit_count == irpd_pkg::LAST_BIT) begin
                    r.byte_valid = 1'b1;
                    r.byte_value = acc;
                    r.byte_index = byte_count;
                    shift_byte   = '0;
                    bit_count    = '0;
                    byte_count   = byte_count + 1'b1;
                    n_bytes++;
                    if (byte_count == irpd_pkg::LAST_BYTE) begin
                        r.frame_done = 1'b1;
                        mode         = irpd_pkg::MODE_IDLE;
                        n_frames++;
                    end
                end else begin
                    shift_byte = acc >> 1;
                    bit_count  = bit_count + 1'b1;
                end
            end

            r.interval     = span;
            r.receiving    = (mode == irpd_pkg::MODE_RECV);
            r.repeat_count = repeats;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, longint exp, longint got);
            if (exp != got) begin
                errors++;
                $display("ERROR %0t: %s expected %0d, got %0d", $time, name, exp, got);
            end
        endfunction

        // Compare one delivered result with the oldest owed one
        function void check_result(irpd_pkg::t_result got);
            irpd_pkg::t_result exp;
            if (expected_results.size() == 0) begin
                errors++;
                $display("ERROR %0t: result with no capture pending (interval %0d)",
                         $time, got.interval);
                return;
            end
            exp = expected_results.pop_front();
            n_checked++;
            compare_field("interval",     exp.interval,     got.interval);
            compare_field("receiving",    exp.receiving,    got.receiving);
            compare_field("byte_valid",   exp.byte_valid,   got.byte_valid);
            compare_field("byte_value",   exp.byte_value,   got.byte_value);
            compare_field("byte_index",   exp.byte_index,   got.byte_index);
            compare_field("frame_done",   exp.frame_done,   got.frame_done);
            compare_field("repeat_count", exp.repeat_count, got.repeat_count);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [irpd_pkg::ADDR_W-1:0]   paddr;
    logic [irpd_pkg::DATA_W-1:0]   pwdata;
    logic [irpd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    irpd_in_if  cap_if ();
    irpd_out_if res_if ();

    ir_frame_tracker             tracker = new();
    logic [irpd_pkg::TIME_W-1:0] sent_last = '0;
    int                          captures_sent;
    int                          n_settings = 1;
    int                          cycle_count;
    bit                          tx_quiet;
    bit                          rx_quiet;
    bit                          hold_res;

    ir_pulse_distance_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (cap_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR %0t: run limit reached, %0d results still owed",
                     $time, tracker.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int                gap;
        irpd_pkg::t_result got;
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(39, 0) == 0) rx_quiet = !rx_quiet;
            if (hold_res) begin
                res_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                hold_res = 1'b0;
            end else begin
                gap = rx_quiet ? 0 : $urandom_range(10, 0);
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            got.interval     = res_if.interval;
            got.receiving    = res_if.receiving;
            got.byte_valid   = res_if.byte_valid;
            got.byte_value   = res_if.byte_value;
            got.byte_index   = res_if.byte_index;
            got.frame_done   = res_if.frame_done;
            got.repeat_count = res_if.repeat_count;
            tracker.check_result(got);
        end
    end

    // One capture request, with a random lead gap
    task automatic send_capture(input logic [irpd_pkg::TIME_W-1:0] t);
        int gap;
        if ($urandom_range(39, 0) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(10, 0);
        if (gap > 0) begin
            cap_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cap_if.valid        <= 1'b1;
        cap_if.capture_time <= t;
        do @(posedge i_clk); while (!cap_if.ready);
        tracker.note_capture(t);
        sent_last = t;
        captures_sent++;
    endtask

    // Capture that lands the given interval after the last one
    task automatic send_interval(input int span);
        if (span > 0 && int'(sent_last) + span <= 65535)
            send_capture(sent_last + irpd_pkg::TIME_W'(span));
        else
            send_capture(irpd_pkg::TIME_W'(int'(sent_last) + span + 1));
    endtask

    task automatic send_bit(input bit b);
        int one_lo  = int'(tracker.cfg.bit_th) + 1;
        int one_hi  = int'(tracker.cfg.bit_max) - 1;
        int zero_hi = (tracker.cfg.bit_th < tracker.cfg.bit_max) ?
                      int'(tracker.cfg.bit_th) : int'(tracker.cfg.bit_max) - 1;
        if (b && one_lo <= one_hi) send_interval($urandom_range(one_hi, one_lo));
        else if (zero_hi >= 1) send_interval($urandom_range(zero_hi, 1));
        else if (one_lo <= one_hi) send_interval($urandom_range(one_hi, one_lo));
        else send_capture(irpd_pkg::TIME_W'($urandom));
    endtask

    // Start pulse plus n_bits data bits; noisy mixes in ignored intervals
    task automatic send_frame(input int n_bits, input bit noisy);
        int lo = int'(tracker.cfg.start_th) + 1;
        int hi = int'(tracker.cfg.start_max) - 1;
        if (lo > hi) begin
            repeat (4) send_capture(irpd_pkg::TIME_W'($urandom));
            return;
        end
        // flush a frame left open by a truncated one
        for (int k = 0; k < 40 && tracker.in_frame(); k++) send_bit($urandom_range(1, 0));
        send_interval($urandom_range(hi, lo));
        for (int i = 0; i < n_bits; i++) begin
            if (noisy && $urandom_range(5, 0) == 0)
                send_interval($urandom_range(65535, int'(tracker.cfg.bit_max)));
            send_bit($urandom_range(1, 0));
        end
    endtask

    task automatic send_repeats(input int n);
        int hi = (tracker.cfg.start_th < tracker.cfg.start_max) ?
                 int'(tracker.cfg.start_th) : int'(tracker.cfg.start_max) - 1;
        if (hi < 1) begin
            repeat (n) send_capture(irpd_pkg::TIME_W'($urandom));
            return;
        end
        repeat (n) send_interval($urandom_range(hi, 1));
    endtask

    // Mostly well-formed frames, some broken ones, repeats and raw noise
    task automatic run_traffic(input int n_items);
        int first = captures_sent;
        int sel;
        while (captures_sent - first < n_items) begin
            sel = $urandom_range(99, 0);
            if (sel < 55) send_frame(FRAME_BITS, 1'b0);
            else if (sel < 63) send_frame($urandom_range(FRAME_BITS - 1, 0), 1'b0);
            else if (sel < 73) send_frame(FRAME_BITS, 1'b1);
            else if (sel < 85) send_repeats($urandom_range(6, 1));
            else repeat ($urandom_range(8, 1)) send_capture(irpd_pkg::TIME_W'($urandom));
        end
    endtask

    // Hold input off until every owed result is back, then settle
    task automatic drain();
        cap_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB setup + access for one register; upper data bits carry junk
    task automatic write_reg(input irpd_pkg::t_reg_idx idx,
                             input logic [irpd_pkg::TIME_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, v);
    endtask

    task automatic write_thresholds(input int sm, input int st, input int bm, input int bt);
        write_reg(irpd_pkg::REG_START_MAX, irpd_pkg::TIME_W'(sm));
        write_reg(irpd_pkg::REG_START_TH,  irpd_pkg::TIME_W'(st));
        write_reg(irpd_pkg::REG_BIT_MAX,   irpd_pkg::TIME_W'(bm));
        write_reg(irpd_pkg::REG_BIT_TH,    irpd_pkg::TIME_W'(bt));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic random_thresholds();
        int st = $urandom_range(20000, 1000);
        int bm = $urandom_range(900, 50);
        write_thresholds(st + $urandom_range(5000, 2), st, bm, $urandom_range(bm - 2, 1));
    endtask

    // Main sequence
    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cap_if.valid        <= 1'b0;
        cap_if.capture_time <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset thresholds, interval extremes and boundaries
        send_capture(16'd0);       // same as reset capture: interval 65535
        send_capture(16'hFFFF);
        send_capture(16'd0);       // wraps to interval 0, counts as repeat
        send_interval(3100);       // at start_th: still a repeat
        send_interval(3600);       // at start_max: ignored
        send_interval(3599);       // frame start
        send_interval(649);
        send_interval(650);        // at bit_max: ignored while receiving
        send_interval(420);
        send_interval(421);
        send_interval(1);
        send_interval(65535);
        send_interval(600);
        send_interval(100);
        send_interval(500);
        send_interval(300);        // eighth bit closes byte 0
        run_traffic(180);
        drain();

        // Defaults rewritten, repeat counter run past its wrap,
        // and one long result stall with requests still coming
        write_thresholds(3600, 3100, 650, 420);
        send_frame(FRAME_BITS, 1'b0);
        send_repeats(300);
        hold_res = 1'b1;
        run_traffic(150);
        drain();

        random_thresholds();
        run_traffic(220);
        drain();

        // Widest windows
        write_thresholds(65535, 0, 65535, 0);
        run_traffic(180);
        drain();

        // Everything ignored
        write_thresholds(0, 0, 0, 0);
        run_traffic(80);
        drain();

        // Everything below 65535 is a repeat
        write_thresholds(65535, 65535, 65535, 65535);
        run_traffic(80);
        drain();

        // One-tick start and one-bit windows
        write_thresholds(3102, 3100, 422, 420);
        run_traffic(200);
        drain();

        random_thresholds();
        run_traffic(220);
        drain();

        $display("Checked %0d captures over %0d threshold settings",
                 tracker.n_checked, n_settings);
        $display("Decoded %0d bytes in %0d complete frames, repeat counter wrapped %0d times",
                 tracker.n_bytes, tracker.n_frames, tracker.n_wraps);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
